[src/ces_pkg.sv]
package ces_pkg;

    localparam int unsigned PRICE_W = 32;
    localparam int unsigned ATR_W   = 40;
    localparam int unsigned OUT_W   = 34;
    localparam int unsigned CFG_W   = 17;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned AGE_W   = 7;

    localparam logic [IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [IDX_W-1:0] REG_MULTIPLIER    = 2'd1;
    localparam logic [IDX_W-1:0] REG_RECIPROCAL    = 2'd2;

    localparam logic [ATR_W-1:0] ATR_MAX = {ATR_W{1'b1}};

    // one bar as passed from the front end to the back end
    typedef struct packed {
        logic [PRICE_W-1:0] high;
        logic [PRICE_W-1:0] low;
        logic [PRICE_W-1:0] close;
    } t_bar;

endpackage

[src/ces_front.sv]
// Input side: a two-entry request queue holding bars until the back end takes them.
module ces_front
    import ces_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  t_bar                i_bar,
    output logic                o_full,
    output logic                o_valid,
    output t_bar                o_bar,
    input  logic                i_take
);
    t_bar       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_bar   = r_q[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_take && o_valid;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= i_bar;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

[src/ces_back.sv]
// Bar processing: window store, extremes, true-range average and exit levels.
module ces_back
    import ces_pkg::*;
#(
    parameter int unsigned MAX_PERIOD = 64
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  t_bar                    i_bar,
    output logic                    o_take,
    input  logic [6:0]              i_window_length,
    input  logic [15:0]             i_multiplier,
    input  logic [16:0]             i_reciprocal,
    output logic                    o_empty,
    input  logic                    i_pop,
    output logic signed [OUT_W-1:0] o_exit_long,
    output logic signed [OUT_W-1:0] o_exit_short
);
    localparam int unsigned SW = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
    localparam int unsigned CW = $clog2(MAX_PERIOD + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_ATR, S_SCAN, S_SCANW, S_MUL, S_OUT, S_HOLD
    } t_state;

    t_state r_state;

    logic [PRICE_W-1:0] r_hwin [MAX_PERIOD];
    logic [PRICE_W-1:0] r_lwin [MAX_PERIOD];
    logic [PRICE_W-1:0] r_hrd, r_lrd;
    logic [SW-1:0]      r_slot, r_raddr;
    logic [PRICE_W-1:0] r_max, r_min, r_prev;
    logic [AGE_W-1:0]   r_max_age, r_min_age;
    logic [ATR_W-1:0]   r_atr;
    logic [CW-1:0]      r_seen, r_n, r_k, r_p;
    logic               r_first, r_scan_hi, r_scan_lo, r_sub, r_emit;
    logic [ATR_W-1:0]   r_diff;
    t_bar               r_bar;
    logic signed [OUT_W-1:0] r_el, r_es;
    logic [56:0]        r_prod;
    logic [CW-1:0]      w_p;

    // effective period, clamped to 1..MAX_PERIOD
    always_comb begin
        if (i_window_length == 7'd0) w_p = CW'(1);
        else if (32'(i_window_length) > MAX_PERIOD) w_p = CW'(MAX_PERIOD);
        else w_p = CW'(i_window_length);
    end

    assign o_take       = (r_state == S_IDLE) && i_valid;
    assign o_empty      = (r_state != S_HOLD);
    assign o_exit_long  = r_el;
    assign o_exit_short = r_es;

    // window memories, registered read
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_hwin[r_slot] <= i_bar.high;
            r_lwin[r_slot] <= i_bar.low;
        end
        r_hrd <= r_hwin[r_raddr];
        r_lrd <= r_lwin[r_raddr];
    end

    logic [PRICE_W-1:0] w_top, w_bot, w_tr;
    logic [AGE_W-1:0]   w_ma, w_na;
    logic [CW-1:0]      w_sn, w_n;
    logic [ATR_W-1:0]   w_trx;
    logic [56:0]        w_dp;
    logic [ATR_W:0]     w_d;
    logic [ATR_W+1:0]   w_sum;
    logic [55:0]        w_mp;
    logic signed [57:0] w_lo, w_hi;
    logic [SW-1:0]      w_newest, w_raddr_back;

    always_comb begin
        w_top = (r_bar.high > r_prev) ? r_bar.high : r_prev;
        w_bot = (r_bar.low < r_prev) ? r_bar.low : r_prev;
        w_tr  = w_top - w_bot;
        w_trx = ATR_W'(w_tr);
        w_ma  = (r_max_age < 7'd127) ? r_max_age + 7'd1 : r_max_age;
        w_na  = (r_min_age < 7'd127) ? r_min_age + 7'd1 : r_min_age;
        w_sn  = r_seen + CW'(1);
        w_n   = (w_sn < r_p) ? w_sn : r_p;
        w_dp  = r_diff * i_reciprocal;
        w_d   = w_dp[56:16];
        w_sum = {2'b0, r_atr} + {1'b0, w_d};
        w_mp  = r_prod[55:0] >> 8;
        w_lo  = $signed({26'd0, r_max}) - $signed({2'b0, w_mp});
        w_hi  = $signed({26'd0, r_min}) + $signed({2'b0, w_mp});
        // slot one step back, wrapping at the window depth
        w_newest     = (r_slot == '0) ? SW'(MAX_PERIOD - 1) : r_slot - SW'(1);
        w_raddr_back = (r_raddr == '0) ? SW'(MAX_PERIOD - 1) : r_raddr - SW'(1);
    end

    // sequencer: take bar, update average, rescan if needed, scale, present
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_slot    <= '0;
            r_max     <= '0;
            r_min     <= '1;
            r_max_age <= '0;
            r_min_age <= '0;
            r_atr     <= '0;
            r_prev    <= '0;
            r_seen    <= '0;
            r_raddr   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_take) begin
                        r_bar   <= i_bar;
                        r_p     <= w_p;
                        r_first <= (r_seen == '0);
                        r_slot  <= (32'(r_slot) == MAX_PERIOD - 1) ? '0 : r_slot + SW'(1);
                        r_state <= S_ATR;
                    end
                end
                S_ATR: begin
                    // set up the average update operand; extremes here
                    r_scan_hi <= 1'b0;
                    r_scan_lo <= 1'b0;
                    if (r_first) begin
                        r_diff <= (r_bar.high >= r_bar.low) ?
                                  ATR_W'(r_bar.high - r_bar.low) : '0;
                        r_sub  <= 1'b0;
                        r_atr  <= '0;
                        r_max  <= r_bar.high;
                        r_min  <= r_bar.low;
                        r_max_age <= '0;
                        r_min_age <= '0;
                        r_seen <= CW'(1);
                        r_state <= S_MUL;
                    end else begin
                        if (r_seen < r_p) begin
                            r_diff <= w_trx; r_sub <= 1'b0;
                        end else if (w_trx >= r_atr) begin
                            r_diff <= w_trx - r_atr; r_sub <= 1'b0;
                        end else begin
                            r_diff <= r_atr - w_trx; r_sub <= 1'b1;
                        end
                        r_max_age <= w_ma;
                        r_min_age <= w_na;
                        if (32'(w_ma) >= 32'(r_p)) r_scan_hi <= 1'b1;
                        else if (r_bar.high >= r_max) begin
                            r_max <= r_bar.high; r_max_age <= '0;
                        end
                        if (32'(w_na) >= 32'(r_p)) r_scan_lo <= 1'b1;
                        else if (r_bar.low <= r_min) begin
                            r_min <= r_bar.low; r_min_age <= '0;
                        end
                        r_n    <= w_n;
                        r_seen <= w_n;
                        r_k    <= '0;
                        r_raddr <= w_newest;
                        r_state <= S_SCANW;
                    end
                end
                S_SCANW: begin
                    // memory read latency, and step back one slot
                    r_raddr <= w_raddr_back;
                    r_state <= (r_scan_hi || r_scan_lo) ? S_SCAN : S_MUL;
                end
                S_SCAN: begin
                    // one entry a cycle, newest first; strict compare keeps newest
                    r_raddr <= w_raddr_back;
                    if (r_scan_hi && (r_k == '0 || r_hrd > r_max)) begin
                        r_max <= r_hrd; r_max_age <= AGE_W'(r_k);
                    end
                    if (r_scan_lo && (r_k == '0 || r_lrd < r_min)) begin
                        r_min <= r_lrd; r_min_age <= AGE_W'(r_k);
                    end
                    r_k <= r_k + CW'(1);
                    if (r_k + CW'(1) >= r_n) r_state <= S_MUL;
                end
                S_MUL: begin
                    // apply the scaled difference, saturating
                    if (r_sub) r_atr <= (w_d > {1'b0, r_atr}) ? '0 : r_atr - w_d[ATR_W-1:0];
                    else r_atr <= (w_sum > {2'b0, ATR_MAX}) ? ATR_MAX : w_sum[ATR_W-1:0];
                    r_prev  <= r_bar.close;
                    r_state <= S_OUT;
                    r_emit  <= 1'b0;
                end
                S_OUT: begin
                    // multiplier times average, then limit the two levels
                    if (!r_emit) begin
                        r_prod <= {17'd0, r_atr} * {41'd0, i_multiplier};
                        r_emit <= 1'b1;
                    end else begin
                        if (w_lo > 58'sd8589934591) r_el <= {1'b0, {(OUT_W-1){1'b1}}};
                        else if (w_lo < -58'sd8589934592) r_el <= {1'b1, {(OUT_W-1){1'b0}}};
                        else r_el <= w_lo[OUT_W-1:0];
                        if (w_hi > 58'sd8589934591) r_es <= {1'b0, {(OUT_W-1){1'b1}}};
                        else r_es <= w_hi[OUT_W-1:0];
                        r_state <= (r_seen >= r_p) ? S_HOLD : S_IDLE;
                    end
                end
                S_HOLD: begin
                    if (i_pop) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[src/chandelier_exit_stream.sv]
// Chandelier exit over a stream of price bars. Bars enter a two-deep request
// queue; the back end handles one bar at a time, through its states (take,
// average update, read wait, scale, present), plus a rescan at one entry a cycle
// when a window extreme ages out and the newest min(period, bars seen) entries
// are rescanned from the window memory. It takes no new bar while a result
// waits to be popped. From bar number period onward each bar gives one
// result, held until popped. Configure only while idle.
module chandelier_exit_stream
    import ces_pkg::*;
#(
    parameter int unsigned MAX_PERIOD = 64
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [PRICE_W-1:0]      i_bar_high,
    input  logic [PRICE_W-1:0]      i_bar_low,
    input  logic [PRICE_W-1:0]      i_bar_close,
    output logic                    empty,
    input  logic                    pop,
    output logic signed [OUT_W-1:0] o_exit_long,
    output logic signed [OUT_W-1:0] o_exit_short,
    input  logic                    i_cfg_we,
    input  logic [IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data
);
    logic [6:0]  r_window_length;
    logic [15:0] r_multiplier;
    logic [16:0] r_reciprocal;
    t_bar        w_in, w_bar;
    logic        w_valid, w_take;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= 7'd14;
            r_multiplier    <= 16'd768;
            r_reciprocal    <= 17'd4681;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WINDOW_LENGTH: r_window_length <= i_cfg_data[6:0];
                REG_MULTIPLIER:    r_multiplier    <= i_cfg_data[15:0];
                REG_RECIPROCAL:    r_reciprocal    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_in = '{high: i_bar_high, low: i_bar_low, close: i_bar_close};

    ces_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .i_bar(w_in), .o_full(full),
        .o_valid(w_valid), .o_bar(w_bar), .i_take(w_take)
    );

    ces_back #(.MAX_PERIOD(MAX_PERIOD)) u_back (
        .i_clk, .i_rst_n, .i_valid(w_valid), .i_bar(w_bar), .o_take(w_take),
        .i_window_length(r_window_length), .i_multiplier(r_multiplier),
        .i_reciprocal(r_reciprocal), .o_empty(empty), .i_pop(pop),
        .o_exit_long, .o_exit_short
    );
endmodule

[bench/tb_chandelier_exit_stream.sv]
`timescale 1ns / 100ps

module tb_chandelier_exit_stream;
    import ces_pkg::*;

    localparam int unsigned WIN_DEPTH = 64;

    // expected exit levels, worked out bar by bar from the prices
    class chandelier_scoreboard;
        bit [PRICE_W-1:0] high_hist[WIN_DEPTH];
        bit [PRICE_W-1:0] low_hist[WIN_DEPTH];
        bit [5:0]         slot;
        bit [PRICE_W-1:0] win_max;
        bit [PRICE_W-1:0] win_min;
        int unsigned      max_age;
        int unsigned      min_age;
        bit [ATR_W-1:0]   atr;
        bit [PRICE_W-1:0] last_close;
        int unsigned      seen;
        bit [6:0]         period_reg;
        bit [15:0]        mult_reg;
        bit [16:0]        recip_reg;
        bit [OUT_W-1:0]   long_q[$];
        bit [OUT_W-1:0]   short_q[$];
        int unsigned      mismatches;

        function new();
            slot = 0; win_max = 0; win_min = '1; max_age = 0; min_age = 0;
            atr = 0; last_close = 0; seen = 0; mismatches = 0;
            period_reg = 14; mult_reg = 768; recip_reg = 4681;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_WINDOW_LENGTH: period_reg = val[6:0];
                REG_MULTIPLIER:    mult_reg   = val[15:0];
                REG_RECIPROCAL:    recip_reg  = val[16:0];
                default: ;
            endcase
        endfunction

        function bit [ATR_W-1:0] atr_add(bit [ATR_W-1:0] a, bit [63:0] d);
            bit [63:0] s;
            s = {24'b0, a} + d;
            return (s > {24'b0, ATR_MAX}) ? ATR_MAX : s[ATR_W-1:0];
        endfunction

        // newest n entries, newest wins a tie
        function void rescan(bit want_max, int unsigned n,
                             output bit [PRICE_W-1:0] best, output int unsigned age);
            bit [PRICE_W-1:0] v;
            bit [5:0]         idx;
            idx = slot;
            best = want_max ? high_hist[idx] : low_hist[idx];
            age = 0;
            for (int unsigned k = 1; k < n; k++) begin
                idx = slot - k[5:0];
                v = want_max ? high_hist[idx] : low_hist[idx];
                if (want_max ? (v > best) : (v < best)) begin
                    best = v;
                    age = k;
                end
            end
        endfunction

        function void note_bar(bit [PRICE_W-1:0] hi, bit [PRICE_W-1:0] lo,
                               bit [PRICE_W-1:0] cl);
            int unsigned      p;
            int unsigned      n;
            bit [PRICE_W-1:0] top;
            bit [PRICE_W-1:0] bot;
            bit [63:0]        tr;
            bit [63:0]        d;
            bit [63:0]        prod;
            longint           el;
            longint           es;
            p = (period_reg == 0) ? 1 : (period_reg > WIN_DEPTH ? WIN_DEPTH : period_reg);
            high_hist[slot] = hi;
            low_hist[slot]  = lo;
            if (seen == 0) begin
                tr = (hi >= lo) ? {32'b0, hi - lo} : 64'd0;
                atr = atr_add(0, (tr * recip_reg) >> 16);
                win_max = hi; win_min = lo; max_age = 0; min_age = 0;
                seen = 1;
            end else begin
                top = (hi > last_close) ? hi : last_close;
                bot = (lo < last_close) ? lo : last_close;
                tr = {32'b0, top - bot};
                n = (seen + 1 < p) ? seen + 1 : p;
                if (seen < p) begin
                    atr = atr_add(atr, (tr * recip_reg) >> 16);
                end else if (tr >= atr) begin
                    atr = atr_add(atr, ((tr - atr) * recip_reg) >> 16);
                end else begin
                    d = ((atr - tr) * recip_reg) >> 16;
                    atr = (d > atr) ? '0 : atr - d[ATR_W-1:0];
                end
                if (max_age < 127) max_age++;
                if (min_age < 127) min_age++;
                if (max_age >= p) rescan(1'b1, n, win_max, max_age);
                else if (hi >= win_max) begin win_max = hi; max_age = 0; end
                if (min_age >= p) rescan(1'b0, n, win_min, min_age);
                else if (lo <= win_min) begin win_min = lo; min_age = 0; end
                seen = n;
            end
            last_close = cl;
            slot = slot + 6'd1;
            if (seen >= p) begin
                prod = ({48'b0, mult_reg} * {24'b0, atr}) >> 8;
                el = longint'({32'b0, win_max}) - longint'(prod);
                es = longint'({32'b0, win_min}) + longint'(prod);
                if (el > 64'sd8589934591) el = 64'sd8589934591;
                if (el < -64'sd8589934592) el = -64'sd8589934592;
                if (es > 64'sd8589934591) es = 64'sd8589934591;
                if (es < -64'sd8589934592) es = -64'sd8589934592;
                long_q.push_back(el[OUT_W-1:0]);
                short_q.push_back(es[OUT_W-1:0]);
            end
        endfunction

        function void check_exits(bit [OUT_W-1:0] el, bit [OUT_W-1:0] es);
            bit [OUT_W-1:0] want_l;
            bit [OUT_W-1:0] want_s;
            if (long_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: long %h short %h", el, es);
                return;
            end
            want_l = long_q.pop_front();
            want_s = short_q.pop_front();
            if (el !== want_l || es !== want_s) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: long exp %h got %h, short exp %h got %h",
                             want_l, el, want_s, es);
            end
        endfunction

        function int unsigned pending();
            return long_q.size();
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    push;
    logic                    full;
    logic [PRICE_W-1:0]      i_bar_high;
    logic [PRICE_W-1:0]      i_bar_low;
    logic [PRICE_W-1:0]      i_bar_close;
    logic                    empty;
    logic                    pop;
    logic signed [OUT_W-1:0] o_exit_long;
    logic signed [OUT_W-1:0] o_exit_short;
    logic                    i_cfg_we;
    logic [IDX_W-1:0]        i_cfg_index;
    logic [CFG_W-1:0]        i_cfg_data;

    chandelier_scoreboard exits_sb;
    bit                   no_idle;
    bit                   hold_request;
    bit [PRICE_W-1:0]     price_level;

    chandelier_exit_stream dut (.*);

    // clock
    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // run limit
    initial begin
        #40ms;
        $display("tb_chandelier_exit_stream failed");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side: random pops, plus one long hold-off on request
    initial begin
        int unsigned hold_left;
        int unsigned gap_left;
        hold_left = 0;
        gap_left = 0;
        pop = 1'b0;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) exits_sb.check_exits(o_exit_long, o_exit_short);
            @(negedge i_clk);
            if (hold_request && hold_left == 0) begin
                hold_request = 1'b0;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                gap_left = pick_gap();
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_bar(bit [PRICE_W-1:0] hi, bit [PRICE_W-1:0] lo,
                            bit [PRICE_W-1:0] cl);
        int unsigned gap;
        bit          taken;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_bar_high <= hi;
        i_bar_low <= lo;
        i_bar_close <= cl;
        do begin
            @(posedge i_clk);
            taken = !full;
            @(negedge i_clk);
        end while (!taken);
        exits_sb.note_bar(hi, lo, cl);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        exits_sb.set_reg(idx, val);
    endtask

    // lets every result drain and the back end settle before a register write
    task automatic drain();
        push <= 1'b0;
        while (exits_sb.pending() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    // mostly well-formed bars around a drifting level, some random noise and extremes
    task automatic random_bar();
        bit [PRICE_W-1:0] hi;
        bit [PRICE_W-1:0] lo;
        bit [PRICE_W-1:0] cl;
        bit [PRICE_W-1:0] spread;
        int unsigned      r;
        r = $urandom_range(99);
        if (r < 80) begin
            spread = $urandom_range(0, 32'h0004_0000);
            price_level = price_level + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
            hi = price_level + spread;
            lo = price_level - $urandom_range(0, spread);
            cl = lo + $urandom_range(0, hi - lo);
        end else if (r < 92) begin
            hi = $urandom; lo = $urandom; cl = $urandom;
        end else begin
            hi = $urandom_range(1) ? '1 : '0;
            lo = $urandom_range(1) ? '1 : '0;
            cl = $urandom_range(1) ? '1 : $urandom;
        end
        send_bar(hi, lo, cl);
    endtask

    initial begin
        bit [PRICE_W-1:0] dir_hi[20];
        bit [PRICE_W-1:0] dir_lo[20];
        bit [PRICE_W-1:0] dir_cl[20];
        bit [6:0]         ph_period[7];
        bit [15:0]        ph_mult[7];
        bit [16:0]        ph_recip[7];
        exits_sb = new();
        no_idle = 1'b0;
        hold_request = 1'b0;
        price_level = 32'h0064_0000;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_bar_high = '0;
        i_bar_low = '0;
        i_bar_close = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_WINDOW_LENGTH;
        i_cfg_data = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed bars under reset settings: inverted first bar, extremes, ties
        dir_hi = '{32'd100, 32'd0, '1, '1, 32'h0001_0000, 32'h0001_0000, 32'd5, '1,
                   32'h8000_0000, 32'h8000_0000, 32'd0, '1, 32'h0010_0000, 32'h0010_0000,
                   32'd7, '1, 32'd0, 32'h7fff_ffff, 32'h0002_0000, 32'h0002_0000};
        dir_lo = '{32'd200, 32'd0, '1, 32'd0, 32'h0001_0000, 32'd0, 32'd5, '1,
                   32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'h0001_0000,
                   32'd7, '1, 32'd0, 32'h7fff_0000, 32'h0001_0000, 32'h0001_0000};
        dir_cl = '{32'd150, '1, 32'd0, '1, 32'h0001_0000, 32'd0, 32'd5, 32'd0,
                   '1, 32'd0, '1, 32'h1234_5678, 32'h0005_0000, 32'h0010_0000,
                   32'd7, 32'd0, '1, 32'h7fff_8000, 32'h0001_8000, 32'h0002_0000};
        foreach (dir_hi[i]) send_bar(dir_hi[i], dir_lo[i], dir_cl[i]);
        drain();

        // fixed settings first, extremes among them; then random ones
        ph_period = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd3, 7'd20, 7'd14};
        ph_mult   = '{16'd65535, 16'd0, 16'd768, 16'd1, 16'd40000, 16'd256, 16'd768};
        ph_recip  = '{17'd65536, 17'd1024, 17'd131071, 17'd1, 17'd21845, 17'd3277,
                      17'd4681};
        for (int ph = 0; ph < 12; ph++) begin
            if (ph < 7) begin
                write_reg(REG_WINDOW_LENGTH, CFG_W'(ph_period[ph]));
                write_reg(REG_MULTIPLIER, CFG_W'(ph_mult[ph]));
                write_reg(REG_RECIPROCAL, ph_recip[ph]);
            end else begin
                write_reg(REG_WINDOW_LENGTH, CFG_W'($urandom_range(1, 64)));
                write_reg(REG_MULTIPLIER, CFG_W'($urandom_range(0, 65535)));
                write_reg(REG_RECIPROCAL, CFG_W'($urandom_range(1, 131071)));
            end
            no_idle = (ph % 4 == 3);
            if (ph == 1) hold_request = 1'b1;
            repeat (145) random_bar();
            drain();
        end

        if (exits_sb.mismatches == 0 && exits_sb.pending() == 0) begin
            $display("tb_chandelier_exit_stream passed");
        end else begin
            $display("tb_chandelier_exit_stream failed");
        end
        $finish;
    end

endmodule

[filelist.f]
src/ces_pkg.sv
src/ces_front.sv
src/ces_back.sv
src/chandelier_exit_stream.sv
bench/tb_chandelier_exit_stream.sv
